// ===== hdl/bsm_pkg.sv =====
// Shared types, constants and the reciprocal table of the 3x3 box smoothing core.
`timescale 1ns / 1ps
package bsm_pkg;

  localparam int MaxWidthDef = 1024;
  localparam int ResetSize   = 32;
  localparam int CfgW        = 11;
  localparam int QueueDepth  = 2;
  localparam int ChanW       = 16;
  localparam int RecipW      = 19;
  localparam int RecipShift  = 18;

  // Input transaction payload
  typedef struct packed {
    logic             func;
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic [ChanW-1:0] alpha_in;
  } in_t;

  // Output transaction payload
  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic [ChanW-1:0] alpha_out;
    logic             frame_last;
  } out_t;

  // Four channels of one pixel, index 3 red down to 0 alpha
  typedef logic [3:0][ChanW-1:0] pix_t;

  // Classified item passed from the front end to the back end
  typedef struct packed {
    pix_t       pix;
    logic       emit;
    logic       top;
    logic       bot;
    logic       lft;
    logic       rgt;
    logic       last;
    logic [3:0] cnt;
  } item_t;

  // floor(2^18 / count) for the neighbour counts that can occur
  function automatic logic [RecipW-1:0] recip(input logic [3:0] cnt);
    logic [RecipW-1:0] r;
    case (cnt)
      4'd1:    r = RecipW'(262144);
      4'd2:    r = RecipW'(131072);
      4'd3:    r = RecipW'(87381);
      4'd4:    r = RecipW'(65536);
      4'd6:    r = RecipW'(43690);
      4'd9:    r = RecipW'(29127);
      default: r = RecipW'(262144);
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/bsm_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module bsm_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                    wdata_i,
  input  logic                                re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bsm_fifo.sv =====
// Small queue between the front end and the back end.
`timescale 1ns / 1ps
module bsm_fifo #(
  parameter int Width = 8,
  parameter int Depth = bsm_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] buf_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= data_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue fill count out of range");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("queue count missed a push");

endmodule

// ===== hdl/bsm_front.sv =====
// Front end: size register, raster position tracking and item classification.
`timescale 1ns / 1ps
module bsm_front #(
  parameter int MaxWidth = bsm_pkg::MaxWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bsm_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bsm_pkg::in_t               in_data_i,
  output logic                       push_o,
  output bsm_pkg::item_t             item_o,
  output logic [(MaxWidth > 1 ? $clog2(MaxWidth) : 1)-1:0] col_o,
  input  logic                       q_ready_i
);

  localparam int CW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int SW = $clog2(MaxWidth + 1);
  localparam int RW = $clog2(MaxWidth + 2);
  localparam logic [SW-1:0] SizeRst =
    SW'((bsm_pkg::ResetSize > MaxWidth) ? MaxWidth : bsm_pkg::ResetSize);

  logic [SW-1:0] size_q, size_d, size_m1;
  logic [CW-1:0] in_c_q, in_c_d, out_c_q, out_c_d;
  logic [RW-1:0] in_r_q, in_r_d;
  logic [CW-1:0] out_r_q, out_r_d;
  logic          acc, emit, last, in_wrap, out_wrap, pix_ok;
  logic          top, bot, lft, rgt;
  logic [3:0]    rows, cols;

  assign in_ready_o = q_ready_i;
  assign acc        = in_valid_i && q_ready_i;
  assign size_m1    = size_q - SW'(1);

  // Classification of the current transaction
  assign in_wrap  = (SW'(in_c_q) == size_m1);
  assign out_wrap = (SW'(out_c_q) == size_m1);
  assign emit     = (in_r_q > RW'(1)) || ((in_r_q == RW'(1)) && (in_c_q != '0));
  assign pix_ok   = !in_data_i.func && (in_r_q < RW'(size_q));
  assign top      = (out_r_q == '0);
  assign bot      = (SW'(out_r_q) == size_m1);
  assign lft      = (out_c_q == '0);
  assign rgt      = out_wrap;
  assign last     = emit && bot && rgt;
  assign rows     = 4'd3 - 4'(top) - 4'(bot);
  assign cols     = 4'd3 - 4'(lft) - 4'(rgt);

  always_comb begin
    item_o      = '0;
    if (pix_ok) begin
      item_o.pix = {in_data_i.red_in, in_data_i.green_in,
                    in_data_i.blue_in, in_data_i.alpha_in};
    end
    item_o.emit = emit;
    item_o.top  = top;
    item_o.bot  = bot;
    item_o.lft  = lft;
    item_o.rgt  = rgt;
    item_o.last = last;
    item_o.cnt  = rows * cols;
  end

  assign col_o  = in_c_q;
  assign push_o = acc;

  // Next position and size
  always_comb begin
    size_d  = size_q;
    in_c_d  = in_c_q;
    in_r_d  = in_r_q;
    out_c_d = out_c_q;
    out_r_d = out_r_q;
    if (cfg_we_i) begin
      if (cfg_data_i == '0) begin
        size_d = SW'(1);
      end else if (32'(cfg_data_i) > MaxWidth) begin
        size_d = SW'(MaxWidth);
      end else begin
        size_d = SW'(cfg_data_i);
      end
      in_c_d  = '0;
      in_r_d  = '0;
      out_c_d = '0;
      out_r_d = '0;
    end else if (acc) begin
      if (last) begin
        in_c_d  = '0;
        in_r_d  = '0;
        out_c_d = '0;
        out_r_d = '0;
      end else begin
        in_c_d = in_wrap ? '0 : in_c_q + CW'(1);
        in_r_d = in_wrap ? in_r_q + RW'(1) : in_r_q;
        if (emit) begin
          out_c_d = out_wrap ? '0 : out_c_q + CW'(1);
          out_r_d = out_wrap ? out_r_q + CW'(1) : out_r_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SizeRst;
      in_c_q  <= '0;
      in_r_q  <= '0;
      out_c_q <= '0;
      out_r_q <= '0;
    end else begin
      size_q  <= size_d;
      in_c_q  <= in_c_d;
      in_r_q  <= in_r_d;
      out_c_q <= out_c_d;
      out_r_q <= out_r_d;
    end
  end

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(in_c_q) < size_q) && (SW'(out_c_q) < size_q))
    else $error("column counter beyond image size");
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && last && !cfg_we_i) |=> (in_c_q == '0 && in_r_q == '0 && out_r_q == '0))
    else $error("frame did not restart after last transaction");

endmodule

// ===== hdl/bsm_back.sv =====
// Back end: line buffers, 3x3 window, masked sums and division by neighbour count.
`timescale 1ns / 1ps
module bsm_back #(
  parameter int MaxWidth = bsm_pkg::MaxWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  bsm_pkg::item_t       q_item_i,
  input  logic [(MaxWidth > 1 ? $clog2(MaxWidth) : 1)-1:0] q_col_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bsm_pkg::out_t        out_data_o
);

  localparam int CW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int PW = $bits(bsm_pkg::pix_t);
  localparam int ChW = bsm_pkg::ChanW;
  localparam int PrW = ChW + bsm_pkg::RecipW;

  logic en, pop, wr_en;

  // Stage 1: line buffer read returns
  logic           v1_q, byp_q;
  bsm_pkg::item_t item1_q;
  logic [CW-1:0]  col1_q;
  bsm_pkg::pix_t  byp_a_q, byp_b_q, lb1_rd, lb2_rd, mid1, top1;

  // Stage 2: window
  logic           v2_q;
  bsm_pkg::item_t meta2_q;
  bsm_pkg::pix_t  win_q [3][3];

  // Stage 3: sums, stage 4: reciprocal products
  logic             v3_q, last3_q, v4_q, last4_q;
  logic [3:0]       cnt3_q, cnt4_q;
  bsm_pkg::pix_t    sum3_d, sum3_q, sum4_q, q04_q, q04_d;
  bsm_pkg::pix_t    res_d;

  logic             out_valid_q;
  bsm_pkg::out_t    out_q;

  assign en      = !out_valid_q || out_ready_i;
  assign pop     = en && q_valid_i;
  assign q_pop_o = pop;
  assign wr_en   = en && v1_q;

  // Line buffers addressed by column
  bsm_ram #(.Width(PW), .Depth(MaxWidth)) u_lb1 (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (col1_q),
    .wdata_i (item1_q.pix),
    .re_i    (pop),
    .raddr_i (q_col_i),
    .rdata_o (lb1_rd)
  );

  bsm_ram #(.Width(PW), .Depth(MaxWidth)) u_lb2 (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (col1_q),
    .wdata_i (mid1),
    .re_i    (pop),
    .raddr_i (q_col_i),
    .rdata_o (lb2_rd)
  );

  // Forward data written in the same cycle as a read of that column
  assign mid1 = byp_q ? byp_a_q : lb1_rd;
  assign top1 = byp_q ? byp_b_q : lb2_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= pop;
      v2_q        <= v1_q;
      v3_q        <= v2_q && meta2_q.emit;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  // Stage 1 and window payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      item1_q <= q_item_i;
      col1_q  <= q_col_i;
      byp_q   <= wr_en && (col1_q == q_col_i);
      byp_a_q <= item1_q.pix;
      byp_b_q <= mid1;
    end
    if (wr_en) begin
      meta2_q    <= item1_q;
      win_q[0][0] <= top1;
      win_q[1][0] <= mid1;
      win_q[2][0] <= item1_q.pix;
      for (int r = 0; r < 3; r++) begin
        win_q[r][1] <= win_q[r][0];
        win_q[r][2] <= win_q[r][1];
      end
    end
  end

  // Masked window sums, wrapping at 16 bits
  always_comb begin
    logic take;
    sum3_d = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        take = !((r == 0) && meta2_q.top) && !((r == 2) && meta2_q.bot) &&
               !((k == 0) && meta2_q.rgt) && !((k == 2) && meta2_q.lft);
        for (int ch = 0; ch < 4; ch++) begin
          if (take) begin
            sum3_d[ch] = sum3_d[ch] + win_q[r][k][ch];
          end
        end
      end
    end
  end

  // Quotient estimate by reciprocal, at most one low
  always_comb begin
    logic [PrW-1:0] prod;
    q04_d = '0;
    for (int ch = 0; ch < 4; ch++) begin
      prod      = PrW'(sum3_q[ch]) * PrW'(bsm_pkg::recip(cnt3_q));
      q04_d[ch] = prod[bsm_pkg::RecipShift +: ChW];
    end
  end

  // Correction step
  always_comb begin
    logic [ChW+3:0] rem;
    res_d = '0;
    for (int ch = 0; ch < 4; ch++) begin
      rem = (ChW + 4)'(sum4_q[ch]) - (ChW + 4)'(q04_q[ch]) * (ChW + 4)'(cnt4_q);
      res_d[ch] = (rem >= (ChW + 4)'(cnt4_q)) ? q04_q[ch] + ChW'(1) : q04_q[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum3_q  <= sum3_d;
      cnt3_q  <= meta2_q.cnt;
      last3_q <= meta2_q.last;
      sum4_q  <= sum3_q;
      q04_q   <= q04_d;
      cnt4_q  <= cnt3_q;
      last4_q <= last3_q;
      if (v4_q) begin
        out_q.red_out    <= res_d[3];
        out_q.green_out  <= res_d[2];
        out_q.blue_out   <= res_d[1];
        out_q.alpha_out  <= res_d[0];
        out_q.frame_last <= last4_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/box_smooth_3x3_core.sv =====
// Top level of the streaming 3x3 box smoothing core.
// Throughput: one transaction per cycle in and out unless stalled; output back-pressure
// fills the queue, which then stalls the input. Pixel p is produced from transaction
// p+size+1 via queue, line buffer read, window, sum, reciprocal multiply, correction.
// Reset: position counters and all valid flags clear, image size returns to 32;
// line buffer contents are left as they are, the border masking never reads them stale.
`timescale 1ns / 1ps
module box_smooth_3x3_core #(
  parameter int MaxWidth = bsm_pkg::MaxWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bsm_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  bsm_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output bsm_pkg::out_t            out_data_o
);

  localparam int CW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int QW = $bits(bsm_pkg::item_t) + CW;

  logic           push, q_ready, q_valid, q_pop;
  bsm_pkg::item_t f_item, b_item;
  logic [CW-1:0]  f_col, b_col;
  logic [QW-1:0]  q_out;

  bsm_front #(.MaxWidth(MaxWidth)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .item_o     (f_item),
    .col_o      (f_col),
    .q_ready_i  (q_ready)
  );

  bsm_fifo #(.Width(QW), .Depth(bsm_pkg::QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_col, f_item}),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_out)
  );

  assign b_col  = q_out[QW-1 -: CW];
  assign b_item = q_out[$bits(bsm_pkg::item_t)-1:0];

  bsm_back #(.MaxWidth(MaxWidth)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (b_item),
    .q_col_i     (b_col),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
